// File: sv/csce_pkg.sv
// Shared types and constants of the capture stack commit engine.
// No dependencies; every other file except csce_ram imports this package.
package csce_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP_H  = 2'd1,
    REQ_POP_T  = 2'd2,
    REQ_COMMIT = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_POPPED   = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FIRED    = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  // Target kinds
  localparam logic [1:0] KIND_VAR  = 2'd0;
  localparam logic [1:0] KIND_PTR  = 2'd1;
  localparam logic [1:0] KIND_CALL = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         target_kind;
    logic [31:0]        target_id;
    logic [31:0]        text_ref;
    logic signed [15:0] text_len;
    logic [5:0]         handle;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  out_handle;
    logic [1:0]  fire_kind;
    logic [31:0] fire_id;
    logic [31:0] fire_text_ref;
    logic [14:0] fire_text_len;
    logic        last;
    logic [5:0]  depth;
  } out_word_t;

  // One stored capture
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [31:0] text_ref;
    logic [14:0] text_len;
  } entry_t;

  // Classified command passed from front to back
  typedef struct packed {
    req_e       op;
    entry_t     entry;
    logic [5:0] handle;
  } cmd_t;

endpackage

// File: sv/capture_stack_commit_engine_core.sv
// Capture stack commit engine, top level: front queue plus back sequencer.
// Depends on csce_pkg, csce_front and csce_back.
//
// Each request word passes a two-word command queue and is then carried out
// by a sequencer over a stack held in one RAM (one read port, registered).
// A request word passes the queue slot and the command register, and its
// result leaves through the output register. Push and an ignored pop by
// handle finish in the execute state. A pop by handle that succeeds and every
// pop-top drop dead entries from the top. Commit steps through the entries,
// skipping dead ones; a live variable or pointer entry with a nonzero id is
// compared with each later live entry for a superseding write, ending at the
// next call entry, and fires unless one is found. A closing state ends the
// commit. A stalled receiver holds the sequencer. Results leave through an
// output register, so the front keeps taking words while a result waits,
// until its queue is full.
module capture_stack_commit_engine_core #(
  parameter int STACK_DEPTH = csce_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csce_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csce_pkg::out_word_t out_word_o
);
  import csce_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  csce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  csce_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

// File: sv/csce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// File: sv/csce_front.sv
// Front end: accepts request words, clamps the length and queues commands.
// Depends on csce_pkg.
module csce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  csce_pkg::in_word_t in_word_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output csce_pkg::cmd_t     cmd_o
);
  import csce_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       push, pop;

  // Classify: negative lengths stored as zero
  always_comb begin
    cls.op             = req_e'(in_word_i.req_type);
    cls.entry.kind     = in_word_i.target_kind;
    cls.entry.id       = in_word_i.target_id;
    cls.entry.text_ref = in_word_i.text_ref;
    cls.entry.text_len = in_word_i.text_len[15] ? 15'd0 : in_word_i.text_len[14:0];
    cls.handle         = in_word_i.handle;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Two-word queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// File: sv/csce_back.sv
// Back end: stack state, commit sequencer and output register.
// Depends on csce_pkg and csce_ram.
module csce_back #(
  parameter int STACK_DEPTH = csce_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  csce_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csce_pkg::out_word_t out_word_o
);
  import csce_pkg::*;

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EXEC   = 9'b000000010,
    S_DROP   = 9'b000000100,
    S_CLOAD  = 9'b000001000,
    S_CLATCH = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_CMP    = 9'b001000000,
    S_FIRE   = 9'b010000000,
    S_CEND   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q;
  logic [CW-1:0]   top_q, top_d, i_q, i_d, j_q, j_d;
  logic            live_q [STACK_DEPTH];
  logic            pop_top_q, pop_top_d;
  entry_t          cur_q, cur_d, pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  logic            out_valid_q;
  out_word_t       out_q, emit_word;
  logic            emit, out_free;

  logic            live_wr, live_val;
  logic [IW-1:0]   live_idx;
  logic            ram_we;
  logic [IW-1:0]   rd_addr;
  entry_t          rd_data;

  logic [6:0]      top7, h7, top_p1;
  logic [5:0]      hm1;
  logic [CW-1:0]   tm1;
  logic [IW-1:0]   h_idx, tm1_idx;
  logic            h_bad;

  csce_ram #(.WIDTH($bits(entry_t)), .DEPTH(STACK_DEPTH)) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(top_q[IW-1:0]),
    .wr_data_i(cmd_q.entry),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cmd_ready_o = (state_q == S_IDLE);

  // Handle and top arithmetic
  always_comb begin
    top7    = 7'(top_q);
    h7      = {1'b0, cmd_q.handle};
    top_p1  = top7 + 7'd1;
    hm1     = cmd_q.handle - 6'd1;
    h_idx   = hm1[IW-1:0];
    tm1     = top_q - CW'(1);
    tm1_idx = tm1[IW-1:0];
    h_bad   = (cmd_q.handle == 6'd0) || (h7 > top7);
    if (!h_bad) h_bad = !live_q[h_idx];
  end

  assign rd_addr = (state_q == S_SCAN) ? j_q[IW-1:0] : i_q[IW-1:0];

  // Sequencer
  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    i_d       = i_q;
    j_d       = j_q;
    pop_top_d = pop_top_q;
    cur_d     = cur_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    live_wr   = 1'b0;
    live_idx  = top_q[IW-1:0];
    live_val  = 1'b0;
    ram_we    = 1'b0;
    emit      = 1'b0;
    emit_word = '0;
    emit_word.status = ST_IGNORED;
    emit_word.last   = 1'b1;
    emit_word.depth  = top7[5:0];
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          case (cmd_q.op)
            REQ_PUSH: begin
              emit = 1'b1;
              state_d = S_IDLE;
              if (top7 >= 7'(STACK_DEPTH)) begin
                emit_word.status = ST_OVERFLOW;
              end else begin
                ram_we   = 1'b1;
                live_wr  = 1'b1;
                live_val = 1'b1;
                top_d    = top_q + CW'(1);
                emit_word.status     = ST_PUSHED;
                emit_word.out_handle = top_p1[5:0];
                emit_word.depth      = top_p1[5:0];
              end
            end
            REQ_POP_H: begin
              if (h_bad) begin
                emit    = 1'b1;
                state_d = S_IDLE;
              end else begin
                live_wr   = 1'b1;
                live_idx  = h_idx;
                pop_top_d = 1'b0;
                state_d   = S_DROP;
              end
            end
            REQ_POP_T: begin
              pop_top_d = 1'b1;
              state_d   = S_DROP;
            end
            REQ_COMMIT: begin
              i_d      = '0;
              pend_v_d = 1'b0;
              state_d  = S_CLOAD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // Drop dead entries at the top, one per cycle
      S_DROP: begin
        if (top_q != '0 && !live_q[tm1_idx]) begin
          top_d = tm1;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          emit_word.status = ST_POPPED;
          if (pop_top_q) begin
            if (top_q == '0) begin
              emit_word.status = ST_IGNORED;
            end else begin
              live_wr  = 1'b1;
              live_idx = tm1_idx;
              top_d    = tm1;
              emit_word.depth = 6'(7'(tm1));
            end
          end
        end
      end
      // Commit: pick next live entry i
      S_CLOAD: begin
        if (i_q >= top_q) begin
          state_d = S_CEND;
        end else if (!live_q[i_q[IW-1:0]]) begin
          i_d = i_q + CW'(1);
        end else begin
          state_d = S_CLATCH;
        end
      end
      S_CLATCH: begin
        cur_d = rd_data;
        if ((rd_data.kind != KIND_VAR && rd_data.kind != KIND_PTR) ||
            rd_data.id == 32'd0) begin
          state_d = S_FIRE;
        end else begin
          j_d     = i_q + CW'(1);
          state_d = S_SCAN;
        end
      end
      // Search later entries for a superseding write
      S_SCAN: begin
        if (j_q >= top_q) begin
          state_d = S_FIRE;
        end else if (!live_q[j_q[IW-1:0]]) begin
          j_d = j_q + CW'(1);
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data.kind == KIND_CALL) begin
          state_d = S_FIRE;
        end else if (rd_data.kind == cur_q.kind && rd_data.id == cur_q.id) begin
          i_d     = i_q + CW'(1);
          state_d = S_CLOAD;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_SCAN;
        end
      end
      // Hold one fired entry back so the final one can carry last
      S_FIRE: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            emit = 1'b1;
            emit_word.status        = ST_FIRED;
            emit_word.fire_kind     = pend_q.kind;
            emit_word.fire_id       = pend_q.id;
            emit_word.fire_text_ref = pend_q.text_ref;
            emit_word.fire_text_len = pend_q.text_len;
            emit_word.last          = 1'b0;
            emit_word.depth         = 6'd0;
          end
          pend_d   = cur_q;
          pend_v_d = 1'b1;
          i_d      = i_q + CW'(1);
          state_d  = S_CLOAD;
        end
      end
      S_CEND: begin
        if (out_free) begin
          emit    = 1'b1;
          top_d   = '0;
          state_d = S_IDLE;
          emit_word.depth = 6'd0;
          if (pend_v_q) begin
            emit_word.status        = ST_FIRED;
            emit_word.fire_kind     = pend_q.kind;
            emit_word.fire_id       = pend_q.id;
            emit_word.fire_text_ref = pend_q.text_ref;
            emit_word.fire_text_len = pend_q.text_len;
          end else begin
            emit_word.status = ST_EMPTY;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      pend_v_q <= pend_v_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (emit) out_q <= emit_word;
    if (live_wr) live_q[live_idx] <= live_val;
    i_q       <= i_d;
    j_q       <= j_d;
    pop_top_q <= pop_top_d;
    cur_q     <= cur_d;
    pend_q    <= pend_d;
  end

endmodule

// File: sv/csce_checker.sv
// Port-level checks of the capture stack commit engine, bound to the top.
// Depends on csce_pkg and capture_stack_commit_engine_core.
module csce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input csce_pkg::out_word_t out_word_o
);
  import csce_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A push handle names the new top entry
  a_push_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_PUSHED |->
      out_word_o.out_handle == out_word_o.depth && out_word_o.last)
    else $error("push handle does not match depth");

  // Commit results leave the stack empty
  a_commit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_FIRED || out_word_o.status == ST_EMPTY)
      |-> out_word_o.depth == 6'd0)
    else $error("commit result with nonzero depth");

  // Only fired words carry entry data, and every other word is last
  a_fire_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_FIRED |->
      out_word_o.fire_id == 32'd0 && out_word_o.fire_text_ref == 32'd0 &&
      out_word_o.fire_text_len == 15'd0 && out_word_o.fire_kind == 2'd0 &&
      out_word_o.last)
    else $error("non-fire word carries entry data");

endmodule

bind capture_stack_commit_engine_core csce_checker u_csce_checker (.*);

// File: verif/capture_stack_commit_engine_core_tb.sv
// Testbench of the capture stack commit engine: directed and random requests.
// Depends on csce_pkg and capture_stack_commit_engine_core.
module capture_stack_commit_engine_core_tb;
  import csce_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  capture_stack_commit_engine_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  // Predictor state: a copy of the capture stack
  int unsigned  cap_top;
  logic         cap_live [DEPTH];
  entry_t       cap_ent  [DEPTH];
  out_word_t    expected_words[$];

  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL capture_stack_commit_engine_core");
    $finish;
  end

  function automatic out_word_t mk_word(status_e st, logic [5:0] h, logic lst);
    out_word_t w;
    w = '0;
    w.status = st;
    w.out_handle = h;
    w.last = lst;
    w.depth = cap_top[5:0];
    return w;
  endfunction

  function automatic void drop_dead_captures();
    while (cap_top > 0 && !cap_live[cap_top-1]) cap_top--;
  endfunction

  // Variable/pointer entry overwritten by a later live write before a call
  function automatic bit is_overwritten(int unsigned i);
    if (cap_ent[i].kind != KIND_VAR && cap_ent[i].kind != KIND_PTR) return 0;
    for (int unsigned j = i + 1; j < cap_top; j++) begin
      if (!cap_live[j]) continue;
      if (cap_ent[j].kind == KIND_CALL) return 0;
      if (cap_ent[j].kind == cap_ent[i].kind && cap_ent[i].id != 0 &&
          cap_ent[j].id == cap_ent[i].id) return 1;
    end
    return 0;
  endfunction

  // Compute the results of one request and update the stack copy
  function automatic void predict_request(in_word_t w);
    int unsigned h;
    int unsigned n;
    bit fires [DEPTH];
    out_word_t r;
    int cnt;
    case (req_e'(w.req_type))
      REQ_PUSH: begin
        if (cap_top >= DEPTH) begin
          expected_words.push_back(mk_word(ST_OVERFLOW, 6'd0, 1'b1));
        end else begin
          cap_live[cap_top] = 1'b1;
          cap_ent[cap_top].kind = w.target_kind;
          cap_ent[cap_top].id = w.target_id;
          cap_ent[cap_top].text_ref = w.text_ref;
          cap_ent[cap_top].text_len = w.text_len[15] ? 15'd0 : w.text_len[14:0];
          cap_top++;
          expected_words.push_back(mk_word(ST_PUSHED, 6'(cap_top), 1'b1));
        end
      end
      REQ_POP_H: begin
        h = w.handle;
        if (h == 0 || h > cap_top || !cap_live[h-1]) begin
          expected_words.push_back(mk_word(ST_IGNORED, 6'd0, 1'b1));
        end else begin
          cap_live[h-1] = 1'b0;
          drop_dead_captures();
          expected_words.push_back(mk_word(ST_POPPED, 6'd0, 1'b1));
        end
      end
      REQ_POP_T: begin
        drop_dead_captures();
        if (cap_top == 0) begin
          expected_words.push_back(mk_word(ST_IGNORED, 6'd0, 1'b1));
        end else begin
          cap_live[cap_top-1] = 1'b0;
          cap_top--;
          expected_words.push_back(mk_word(ST_POPPED, 6'd0, 1'b1));
        end
      end
      default: begin
        n = cap_top;
        for (int unsigned i = 0; i < n; i++) fires[i] = cap_live[i] && !is_overwritten(i);
        cap_top = 0;
        cnt = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (!fires[i]) continue;
          r = mk_word(ST_FIRED, 6'd0, 1'b0);
          r.fire_kind = cap_ent[i].kind;
          r.fire_id = cap_ent[i].id;
          r.fire_text_ref = cap_ent[i].text_ref;
          r.fire_text_len = cap_ent[i].text_len;
          expected_words.push_back(r);
          cnt++;
        end
        if (cnt == 0) expected_words.push_back(mk_word(ST_EMPTY, 6'd0, 1'b1));
        else expected_words[$].last = 1'b1;
      end
    endcase
  endfunction

  // Send one request word, with random idle cycles ahead of it
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_word_t push_word(logic [1:0] k, logic [31:0] id,
                                         logic [31:0] ref_v, logic [15:0] len);
    in_word_t w;
    w = '0;
    w.req_type = REQ_PUSH;
    w.target_kind = k;
    w.target_id = id;
    w.text_ref = ref_v;
    w.text_len = len;
    w.handle = 6'($urandom);
    return w;
  endfunction

  function automatic in_word_t op_word(req_e op, logic [5:0] h);
    in_word_t w;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    w = rnd[$bits(in_word_t)-1:0];
    w.req_type = op;
    w.handle = h;
    return w;
  endfunction

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", out_word);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word !== exp_w) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h actual %h", exp_w, out_word);
        end
      end
    end
  end

  // Receiver stall process with a long hold-off window
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_word(op_word(REQ_COMMIT, 6'd0));      // commit of empty stack
    send_word(op_word(REQ_POP_T, 6'd0));       // empty pop-top
    send_word(op_word(REQ_POP_H, 6'd0));       // null handle
    send_word(push_word(KIND_VAR, 32'd7, 32'hFFFF_FFFF, 16'sh7FFF));
    send_word(push_word(KIND_VAR, 32'd7, 32'd0, 16'sh8000));   // negative length
    send_word(push_word(KIND_PTR, 32'd0, 32'd1, -16'sd1));
    send_word(push_word(KIND_PTR, 32'd0, 32'd2, 16'sd0));      // null id, no overwrite
    send_word(push_word(2'd3, 32'd7, 32'd3, 16'sd5));          // kind code three
    send_word(push_word(KIND_CALL, 32'hFFFF_FFFF, 32'd4, 16'sd9));
    send_word(push_word(KIND_VAR, 32'd7, 32'd5, 16'sd1));
    send_word(op_word(REQ_POP_H, 6'd40));      // handle above top
    send_word(op_word(REQ_POP_H, 6'd4));
    send_word(op_word(REQ_POP_H, 6'd4));       // stale handle
    send_word(op_word(REQ_POP_H, 6'd7));
    send_word(op_word(REQ_POP_T, 6'd0));
    send_word(op_word(REQ_COMMIT, 6'd0));
    wait_drained();
  endtask

  // Fill the stack past full while the receiver holds off
  task automatic test_overflow();
    hold_cycles = 300;
    for (int i = 0; i < DEPTH + 2; i++)
      send_word(push_word(2'($urandom_range(2)), 32'($urandom_range(3)),
                          $urandom, 16'($urandom)));
    send_word(op_word(REQ_COMMIT, 6'd0));
    wait_drained();
  endtask

  task automatic test_random(int n_items);
    int unsigned pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_word(push_word(2'($urandom_range(3)),
                            ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3)),
                            $urandom, 16'($urandom)));
      else if (pick < 78)
        send_word(op_word(REQ_POP_H, 6'($urandom_range(cap_top + 2))));
      else if (pick < 88)
        send_word(op_word(REQ_POP_H, 6'($urandom)));
      else if (pick < 94)
        send_word(op_word(REQ_POP_T, 6'd0));
      else
        send_word(op_word(REQ_COMMIT, 6'd0));
    end
    send_word(op_word(REQ_COMMIT, 6'd0));
    wait_drained();
  endtask

  initial begin
    errors = 0;
    cap_top = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      cap_live[i] = 1'b0;
      cap_ent[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(27);
    send_idle_pct = 75;
    test_random(27);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    test_random(27);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    test_random(27);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS capture_stack_commit_engine_core");
    end else begin
      $display("FAIL capture_stack_commit_engine_core");
    end
    $finish;
  end

endmodule
